### hw/rtl/mts_pkg.sv
// Shared types and constants for the markup tag stripper.
// Holds the channel payload structs, the entity table and the result set struct.
// No dependencies.
package mts_pkg;

   localparam int HoldDepth  = 5;
   localparam int MaxResults = HoldDepth + 1;
   localparam int EntCount   = 4;
   localparam int EntSpan    = 8;

   localparam logic [7:0] CHAR_LT  = 8'h3C;
   localparam logic [7:0] CHAR_GT  = 8'h3E;
   localparam logic [7:0] CHAR_AMP = 8'h26;
   localparam logic [7:0] CHAR_NL  = 8'h0A;
   localparam logic [7:0] CHAR_SP  = 8'h20;

   // entity spellings, zero padded; order sets match priority
   localparam logic [7:0] ENT_TEXT [EntCount][EntSpan] = '{
      '{"&", "l", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"&", "g", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"&", "n", "b", "s", "p", ";", 8'h00, 8'h00},
      '{"&", "a", "m", "p", ";", 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] ENT_LEN [EntCount] = '{3'd4, 3'd4, 3'd6, 3'd5};
   localparam logic [7:0] ENT_VALUE [EntCount] = '{CHAR_LT, CHAR_GT, CHAR_SP, CHAR_AMP};

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_end;
   } rsp_item_type;

   // results caused by one accepted word
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [2:0]                 count;
      logic                       text_last;
   } result_set_type;

endpackage

### hw/rtl/mts_stream_if.sv
// Valid/ready stream channel used on both sides of the tag stripper.
// The payload type is set per instance; no package dependency.
interface mts_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/markup_tag_stripper_top.sv
// Markup tag stripper: drops tags, folds a tag holding a newline to one newline,
// decodes the entities for less-than, greater-than, non-breaking space and ampersand.
// The first result byte is registered and is valid in the cycle after the input word is accepted.
// Throughput: one input word per cycle while each word yields at most one result and the output is ready;
// a word yielding n results (up to six, on an entity flush) holds off the next until its last result is taken.
// Reset (synchronous): leaves markup, drops any held entity and empties the result register.
module markup_tag_stripper_top
   import mts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   mts_stream_if.sink   req_chan,
   mts_stream_if.source rsp_chan
);

   logic           accept;
   logic           can_take;
   result_set_type result;

   assign req_chan.ready = can_take;
   assign accept         = req_chan.valid && can_take;

   mts_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_chan.payload.in_byte),
      .in_last (req_chan.payload.in_last),
      .result  (result)
   );

   mts_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .set_in   (result),
      .can_take (can_take),
      .rsp_chan (rsp_chan)
   );

endmodule

### hw/rtl/mts_parse.sv
// Tag and entity state of the stripper, and the result set for one input word.
// Depends on mts_pkg.
module mts_parse
   import mts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     in_byte,
   input  logic           in_last,
   output result_set_type result
);

   logic                 inside_tag_ff, inside_tag_in;
   logic                 tag_saw_newline_ff, tag_saw_newline_in;
   logic [2:0]           entity_count_ff, entity_count_in;
   logic [HoldDepth-1:0][7:0] entity_held_ff;

   logic       hit, done;
   logic [7:0] hit_value;
   logic       held_wr_en;
   logic [2:0] held_wr_idx;
   logic       use_held;
   logic       extra_v;
   logic [7:0] extra;
   logic [2:0] hold_len;

   // match the held run plus the new byte against each entity
   always_comb begin
      logic m;
      hit       = 1'b0;
      done      = 1'b0;
      hit_value = '0;
      for (int k = EntCount - 1; k >= 0; k--) begin
         m = ({1'b0, entity_count_ff} + 4'd1 <= {1'b0, ENT_LEN[k]})
             && (in_byte == ENT_TEXT[k][entity_count_ff]);
         for (int i = 0; i < HoldDepth; i++) begin
            if (3'(i) < entity_count_ff && entity_held_ff[i] != ENT_TEXT[k][i]) begin
               m = 1'b0;
            end
         end
         if (m) begin
            hit       = 1'b1;
            done      = (entity_count_ff + 3'd1 == ENT_LEN[k]);
            hit_value = ENT_VALUE[k];
         end
      end
   end

   always_comb begin
      logic fresh;
      inside_tag_in      = inside_tag_ff;
      tag_saw_newline_in = tag_saw_newline_ff;
      entity_count_in    = entity_count_ff;
      held_wr_en         = 1'b0;
      held_wr_idx        = '0;
      use_held           = 1'b0;
      extra_v            = 1'b0;
      extra              = in_byte;
      fresh              = 1'b0;

      if (inside_tag_ff) begin
         if (in_byte == CHAR_NL) begin
            tag_saw_newline_in = 1'b1;
         end else if (in_byte == CHAR_GT) begin
            extra_v            = tag_saw_newline_ff;
            extra              = CHAR_NL;
            inside_tag_in      = 1'b0;
            tag_saw_newline_in = 1'b0;
         end
      end else if (entity_count_ff != 3'd0) begin
         if (hit) begin
            if (done) begin
               extra_v         = 1'b1;
               extra           = hit_value;
               entity_count_in = '0;
            end else begin
               held_wr_en      = 1'b1;
               held_wr_idx     = entity_count_ff;
               entity_count_in = entity_count_ff + 3'd1;
               // end of text: flush the grown run at once
               if (in_last) begin
                  use_held = 1'b1;
                  extra_v  = 1'b1;
               end
            end
         end else begin
            use_held        = 1'b1;
            entity_count_in = '0;
            fresh           = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end

      if (fresh) begin
         if (in_byte == CHAR_LT) begin
            inside_tag_in      = 1'b1;
            tag_saw_newline_in = 1'b0;
         end else if (in_byte == CHAR_AMP) begin
            held_wr_en      = 1'b1;
            held_wr_idx     = '0;
            entity_count_in = 3'd1;
            extra_v         = in_last;
         end else begin
            extra_v = 1'b1;
         end
      end

      if (in_last) begin
         inside_tag_in      = 1'b0;
         tag_saw_newline_in = 1'b0;
         entity_count_in    = '0;
      end
   end

   // held bytes first, then the one extra byte
   always_comb begin
      hold_len         = use_held ? entity_count_ff : 3'd0;
      result.count     = hold_len + {2'b00, extra_v};
      result.text_last = in_last;
      for (int i = 0; i < HoldDepth; i++) begin
         result.bytes[i] = (3'(i) < hold_len) ? entity_held_ff[i] : extra;
      end
      result.bytes[MaxResults-1] = extra;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_tag_ff      <= 1'b0;
         tag_saw_newline_ff <= 1'b0;
         entity_count_ff    <= '0;
      end else if (accept) begin
         inside_tag_ff      <= inside_tag_in;
         tag_saw_newline_ff <= tag_saw_newline_in;
         entity_count_ff    <= entity_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && held_wr_en) begin
         entity_held_ff[held_wr_idx] <= in_byte;
      end
   end

endmodule

### hw/rtl/mts_emit.sv
// Result register of the stripper: holds one result set and hands it out a byte a word.
// Depends on mts_pkg and mts_stream_if.
module mts_emit
   import mts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  result_set_type set_in,
   output logic           can_take,
   mts_stream_if.source   rsp_chan
);

   logic [MaxResults-1:0][7:0] bytes_ff;
   logic [2:0]                 count_ff;
   logic [2:0]                 ptr_ff;
   logic                       text_last_ff;
   logic                       have;
   logic                       final_word;
   logic                       fire;

   assign have       = (count_ff != 3'd0);
   assign final_word = (ptr_ff + 3'd1 == count_ff);
   assign fire       = have && rsp_chan.ready;
   assign can_take   = !have || (rsp_chan.ready && final_word);

   assign rsp_chan.valid            = have;
   assign rsp_chan.payload.out_byte = bytes_ff[ptr_ff];
   assign rsp_chan.payload.run_last = final_word;
   assign rsp_chan.payload.text_end = final_word && text_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else if (load) begin
         count_ff <= set_in.count;
         ptr_ff   <= '0;
      end else if (fire) begin
         if (final_word) begin
            count_ff <= '0;
            ptr_ff   <= '0;
         end else begin
            ptr_ff <= ptr_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff     <= set_in.bytes;
         text_last_ff <= set_in.text_last;
      end
   end

endmodule

### bench/testbench.sv
// Self-checking bench for markup_tag_stripper_top: streams text bytes in and checks
// every cleaned byte against a behavioural predictor of tags, entities and text ends.
// Depends on mts_pkg and mts_stream_if from the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mts_pkg::*;

   localparam logic [7:0] LT_CH  = 8'h3C;
   localparam logic [7:0] GT_CH  = 8'h3E;
   localparam logic [7:0] AMP_CH = 8'h26;
   localparam logic [7:0] NL_CH  = 8'h0A;
   localparam logic [7:0] SP_CH  = 8'h20;
   localparam int TARGET_WORDS   = 260;
   localparam int DRAIN_CYCLES   = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mts_stream_if #(.payload_type(req_item_type)) req_if ();
   mts_stream_if #(.payload_type(rsp_item_type)) rsp_if ();

   markup_tag_stripper_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state
   string      ent_spell [4] = '{"&lt;", "&gt;", "&nbsp;", "&amp;"};
   logic [7:0] ent_glyph [4] = '{LT_CH, GT_CH, SP_CH, AMP_CH};
   bit         in_markup = 1'b0;
   bit         markup_nl = 1'b0;
   logic [7:0] held_bytes [5];
   int         held_n = 0;
   logic [7:0] step_bytes [$];
   rsp_item_type cleaned_q [$];

   int  fault_count = 0;
   int  words_sent = 0;
   int  long_hold = 0;
   bit  steady_feed = 1'b0;
   bit  steady_drain = 1'b0;
   logic [7:0] text_buf [$];

   function automatic void spill_held();
      for (int i = 0; i < held_n; i++) step_bytes.push_back(held_bytes[i]);
      held_n = 0;
   endfunction

   function automatic void take_fresh(logic [7:0] b);
      if (b == LT_CH) begin
         in_markup = 1'b1;
         markup_nl = 1'b0;
      end else if (b == AMP_CH) begin
         held_bytes[0] = b;
         held_n = 1;
      end else begin
         step_bytes.push_back(b);
      end
   endfunction

   function automatic bit grow_entity(logic [7:0] b);
      logic [7:0] cand [6];
      int n;
      bit hit;
      for (int i = 0; i < held_n; i++) cand[i] = held_bytes[i];
      cand[held_n] = b;
      n = held_n + 1;
      for (int k = 0; k < 4; k++) begin
         if (n <= ent_spell[k].len()) begin
            hit = 1'b1;
            for (int i = 0; i < n; i++)
               if (cand[i] != 8'(ent_spell[k][i])) hit = 1'b0;
            if (hit) begin
               if (n == ent_spell[k].len()) begin
                  step_bytes.push_back(ent_glyph[k]);
                  held_n = 0;
               end else begin
                  for (int i = 0; i < n; i++) held_bytes[i] = cand[i];
                  held_n = n;
               end
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic void predict_cleaned(req_item_type w);
      rsp_item_type r;
      step_bytes.delete();
      if (in_markup) begin
         if (w.in_byte == NL_CH) begin
            markup_nl = 1'b1;
         end else if (w.in_byte == GT_CH) begin
            if (markup_nl) step_bytes.push_back(NL_CH);
            in_markup = 1'b0;
            markup_nl = 1'b0;
         end
      end else if (held_n > 0) begin
         if (!grow_entity(w.in_byte)) begin
            spill_held();
            take_fresh(w.in_byte);
         end
      end else begin
         take_fresh(w.in_byte);
      end
      if (w.in_last) begin
         spill_held();
         in_markup = 1'b0;
         markup_nl = 1'b0;
      end
      foreach (step_bytes[i]) begin
         r.out_byte = step_bytes[i];
         r.run_last = (i == step_bytes.size() - 1);
         r.text_end = r.run_last && w.in_last;
         cleaned_q.push_back(r);
      end
   endfunction

   function automatic void note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         predict_cleaned(req_if.payload);
         words_sent++;
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (cleaned_q.size() == 0) begin
            note_fault($sformatf("unexpected byte %02h run_last %0b text_end %0b",
                                 got.out_byte, got.run_last, got.text_end));
         end else begin
            want = cleaned_q.pop_front();
            if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
                got.text_end !== want.text_end)
               note_fault($sformatf({"mismatch: expected byte %02h run_last %0b text_end %0b,",
                                     " got byte %02h run_last %0b text_end %0b"},
                                    want.out_byte, want.run_last, want.text_end,
                                    got.out_byte, got.run_last, got.text_end));
         end
      end
   end

   // result side: random stall per word, or a long hold when asked
   initial begin : drain_side
      int stall;
      rsp_if.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (long_hold > 0) stall = long_hold;
         else stall = steady_drain ? 0 : $urandom_range(0, 12);
         long_hold = 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   task automatic send_word(logic [7:0] b, logic last);
      int gap;
      gap = steady_feed ? 0 : $urandom_range(0, 12);
      @(negedge clock);
      repeat (gap) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= '{in_byte: b, in_last: last};
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_word(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (cleaned_q.size() != 0) @(posedge clock);
   endtask

   function automatic void push_str(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   // build a text of well-formed tags and entities mixed with random bytes, partial entities and stray closes
   function automatic void compose_text(int tokens);
      int k;
      int span;
      logic [7:0] b;
      repeat (tokens) begin
         k = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0, 1, 2: text_buf.push_back(8'($urandom_range(0, 255)));
            3, 4: push_str(ent_spell[k]);
            5: begin
               push_str(ent_spell[k].substr(0, $urandom_range(0, ent_spell[k].len() - 2)));
               text_buf.push_back(8'($urandom_range(0, 255)));
            end
            6, 7: begin
               text_buf.push_back(LT_CH);
               span = $urandom_range(0, 5);
               repeat (span) begin
                  b = 8'($urandom_range(0, 255));
                  if ($urandom_range(0, 3) == 0) b = NL_CH;
                  if (b == GT_CH) b = "a";
                  text_buf.push_back(b);
               end
               text_buf.push_back(GT_CH);
            end
            8: text_buf.push_back(GT_CH);
            default: begin
               // decoded ampersand must not start a new entity
               push_str("&amp;");
               push_str(ent_spell[k].substr(1, ent_spell[k].len() - 1));
            end
         endcase
      end
   endfunction

   task automatic test_directed_texts();
      // extremes, stray close, newline tag, plain tag closing the text with no output
      text_buf.push_back(8'h00);
      text_buf.push_back(8'hFF);
      push_str(">");
      push_str("<a");
      text_buf.push_back(NL_CH);
      push_str("><b>");
      send_text();
      // decode, open tag within a partial entity, partial entity flushed at the end
      push_str("&lt;&am<x>&nb");
      send_text();
      // tag left open at the end of the text
      push_str("<z");
      send_text();
   endtask

   task automatic test_steady_stream();
      steady_feed = 1'b1;
      steady_drain = 1'b1;
      compose_text(15);
      send_text();
      steady_feed = 1'b0;
      steady_drain = 1'b0;
   endtask

   task automatic test_backpressure();
      wait_drained();
      long_hold = 80;
      steady_feed = 1'b1;
      compose_text(15);
      send_text();
      steady_feed = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_texts();
      while (words_sent < TARGET_WORDS) begin
         compose_text($urandom_range(1, 12));
         send_text();
         if ($urandom_range(0, 5) == 0) wait_drained();
      end
   endtask

   initial begin : limit
      #3ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin : run
      req_if.valid = 1'b0;
      req_if.payload = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed_texts();
      test_steady_stream();
      test_backpressure();
      test_random_texts();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && cleaned_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### markup_tag_stripper_top.f
hw/rtl/mts_pkg.sv
hw/rtl/mts_stream_if.sv
hw/rtl/mts_parse.sv
hw/rtl/mts_emit.sv
hw/rtl/markup_tag_stripper_top.sv
bench/testbench.sv
